@@ sv/d7s_pkg.sv @@
// shared types, constants and the segment table for the seven-segment decoder
// no dependencies

package d7s_pkg;

  typedef logic [6:0] seg_t;
  typedef logic [3:0] bcd_t;

  localparam int unsigned MAG_W = 14;
  localparam int unsigned PROD_W = 30;

  localparam logic [MAG_W-1:0] MAX_SHOWN = 14'd9999;

  // reciprocal constants, exact for every magnitude below 2**14
  localparam logic [15:0] DIV10_MUL = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam logic [15:0] DIV100_MUL = 16'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [15:0] DIV1000_MUL = 16'd8389;
  localparam int unsigned DIV1000_SHIFT = 23;

  localparam seg_t SEG_BLANK = 7'd0;
  localparam seg_t SEG_E = 7'd121;
  localparam seg_t SEG_R = 7'd80;

  typedef struct packed {
    bcd_t units;
    bcd_t tens;
    bcd_t hundreds;
    bcd_t thousands;
    logic tens_blank;
    logic hundreds_blank;
    logic thousands_blank;
    logic err;
  } digits_t;

  typedef struct packed {
    seg_t units;
    seg_t tens;
    seg_t hundreds;
    seg_t thousands;
    logic err;
  } segs_t;

  function automatic seg_t seg_of(input bcd_t digit);
    seg_t pattern;
    case (digit)
      4'd0: pattern = 7'd63;
      4'd1: pattern = 7'd6;
      4'd2: pattern = 7'd91;
      4'd3: pattern = 7'd79;
      4'd4: pattern = 7'd102;
      4'd5: pattern = 7'd109;
      4'd6: pattern = 7'd125;
      4'd7: pattern = 7'd7;
      4'd8: pattern = 7'd127;
      4'd9: pattern = 7'd103;
      default: pattern = SEG_BLANK;
    endcase
    return pattern;
  endfunction

endpackage

@@ sv/decimal_to_seven_segment.sv @@
// top level of the four-digit seven-segment decoder
// depends on d7s_pkg, d7s_digit_split and d7s_seg_encode

// A request is taken on any cycle with start high and busy low; busy is high
// only while rst is held, so one value can be taken every clock. Each value
// gives one result: done pulses for a single cycle with the four segment
// patterns and out_of_range on the result ports. The value passes through
// the input register and then the result register, with the digit split and
// the segment lookup between them. The receiver cannot stall the block, so the
// result must be captured in the cycle that done is high.

module decimal_to_seven_segment
  import d7s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [15:0] value,
  output logic              busy,
  output logic              done,
  output logic [6:0]        units_segments,
  output logic [6:0]        tens_segments,
  output logic [6:0]        hundreds_segments,
  output logic [6:0]        thousands_segments,
  output logic              out_of_range
);

  logic               in_valid;
  logic signed [15:0] value_reg;
  digits_t            digits;
  segs_t              segs;
  segs_t              result;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value_reg <= value;
    end
    if (in_valid) begin
      result <= segs;
    end
  end

  d7s_digit_split u_split (
    .value  (value_reg),
    .digits (digits)
  );

  d7s_seg_encode u_encode (
    .digits (digits),
    .segs   (segs)
  );

  assign units_segments     = result.units;
  assign tens_segments      = result.tens;
  assign hundreds_segments  = result.hundreds;
  assign thousands_segments = result.thousands;
  assign out_of_range       = result.err;

endmodule

@@ sv/d7s_digit_split.sv @@
// splits a registered value into four decimal digits with blanking flags and an error flag
// depends on d7s_pkg

module d7s_digit_split
  import d7s_pkg::*;
(
  input  logic signed [15:0] value,
  output digits_t            digits
);

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] p10;
  logic [PROD_W-1:0] p100;
  logic [PROD_W-1:0] p1000;
  logic [9:0]        q10;
  logic [6:0]        q100;
  logic [3:0]        q1000;
  logic [MAG_W-1:0]  rem0;
  logic [9:0]        rem1;
  logic [6:0]        rem2;

  assign mag = value[MAG_W-1:0];

  // three independent reciprocal multiplies
  assign p10   = PROD_W'(mag) * PROD_W'(DIV10_MUL);
  assign p100  = PROD_W'(mag) * PROD_W'(DIV100_MUL);
  assign p1000 = PROD_W'(mag) * PROD_W'(DIV1000_MUL);

  assign q10   = p10[DIV10_SHIFT +: 10];
  assign q100  = p100[DIV100_SHIFT +: 7];
  assign q1000 = p1000[DIV1000_SHIFT +: 4];

  // digit = quotient minus ten times the next quotient
  assign rem0 = mag - (MAG_W'({q10, 3'b000}) + MAG_W'({q10, 1'b0}));
  assign rem1 = q10 - (10'({q100, 3'b000}) + 10'({q100, 1'b0}));
  assign rem2 = q100 - (7'({q1000, 3'b000}) + 7'({q1000, 1'b0}));

  always_comb begin
    digits.units           = rem0[3:0];
    digits.tens            = rem1[3:0];
    digits.hundreds        = rem2[3:0];
    digits.thousands       = q1000;
    digits.tens_blank      = (q10 == 10'd0);
    digits.hundreds_blank  = (q100 == 7'd0);
    digits.thousands_blank = (q1000 == 4'd0);
    digits.err             = value[15] || (value[14:0] > 15'(MAX_SHOWN));
  end

endmodule

@@ sv/d7s_seg_encode.sv @@
// maps decimal digits to segment patterns, with blanking and the error text
// depends on d7s_pkg

module d7s_seg_encode
  import d7s_pkg::*;
(
  input  digits_t digits,
  output segs_t   segs
);

  always_comb begin
    if (digits.err) begin
      segs.units     = SEG_R;
      segs.tens      = SEG_R;
      segs.hundreds  = SEG_E;
      segs.thousands = SEG_BLANK;
      segs.err       = 1'b1;
    end else begin
      segs.units     = seg_of(digits.units);
      segs.tens      = digits.tens_blank ? SEG_BLANK : seg_of(digits.tens);
      segs.hundreds  = digits.hundreds_blank ? SEG_BLANK : seg_of(digits.hundreds);
      segs.thousands = digits.thousands_blank ? SEG_BLANK : seg_of(digits.thousands);
      segs.err       = 1'b0;
    end
  end

endmodule

@@ sv/d7s_checker.sv @@
// port-level checks on the seven-segment decoder, bound to its top level
// depends on decimal_to_seven_segment

module d7s_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [6:0] units_segments,
  input logic [6:0] tens_segments,
  input logic [6:0] hundreds_segments,
  input logic [6:0] thousands_segments,
  input logic       out_of_range
);

  // every request is followed by a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without request");

  // error text
  a_err_text: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |->
      (units_segments == 7'd80 && tens_segments == 7'd80 &&
       hundreds_segments == 7'd121 && thousands_segments == 7'd0))
    else $error("wrong error pattern");

  // units digit never blank on a valid number
  a_units_shown: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> units_segments != 7'd0)
    else $error("units digit blanked");

  // no inner digit blank when the thousands digit is shown
  a_leading_blank: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range && thousands_segments != 7'd0) |->
      (hundreds_segments != 7'd0 && tens_segments != 7'd0))
    else $error("inner digit blanked");

endmodule

bind decimal_to_seven_segment d7s_checker u_d7s_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .done               (done),
  .units_segments     (units_segments),
  .tens_segments      (tens_segments),
  .hundreds_segments  (hundreds_segments),
  .thousands_segments (thousands_segments),
  .out_of_range       (out_of_range)
);

@@ tb/sv/tb_decimal_to_seven_segment.sv @@
// self-checking testbench for the four-digit seven-segment decoder
// depends on d7s_pkg and decimal_to_seven_segment; predicts each result from the value

module tb_decimal_to_seven_segment;
  import d7s_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    segs_t segs;
  } display_t;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;

  localparam seg_t DIGIT_GLYPH [10] = '{
    7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd103
  };

  logic clk;
  logic rst;
  logic start = 1'b0;
  logic signed [15:0] value = '0;
  logic busy;
  logic done;
  logic [6:0] units_segments;
  logic [6:0] tens_segments;
  logic [6:0] hundreds_segments;
  logic [6:0] thousands_segments;
  logic out_of_range;

  logic signed [15:0] value_queue [$];
  int unsigned gap_queue [$];
  display_t pending_displays [$];
  int unsigned gap_left = 0;
  bit taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  decimal_to_seven_segment u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .value              (value),
    .busy               (busy),
    .done               (done),
    .units_segments     (units_segments),
    .tens_segments      (tens_segments),
    .hundreds_segments  (hundreds_segments),
    .thousands_segments (thousands_segments),
    .out_of_range       (out_of_range)
  );

  function automatic segs_t predict_display(input logic signed [15:0] v);
    segs_t s;
    int n;
    n = v;
    if (n < 0 || n > 9999) begin
      s.units = SEG_R;
      s.tens = SEG_R;
      s.hundreds = SEG_E;
      s.thousands = SEG_BLANK;
      s.err = 1'b1;
    end else begin
      s.units = DIGIT_GLYPH[n % 10];
      s.tens = (n >= 10) ? DIGIT_GLYPH[(n / 10) % 10] : SEG_BLANK;
      s.hundreds = (n >= 100) ? DIGIT_GLYPH[(n / 100) % 10] : SEG_BLANK;
      s.thousands = (n >= 1000) ? DIGIT_GLYPH[(n / 1000) % 10] : SEG_BLANK;
      s.err = 1'b0;
    end
    return s;
  endfunction

  function automatic logic signed [15:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(10, 99));
      2: return 16'($urandom_range(100, 999));
      3, 4, 5: return 16'($urandom_range(1000, 9999));
      6: return 16'($urandom_range(10000, 32767));
      7: return -16'sd1 - 16'($urandom_range(0, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    logic next_start;
    logic signed [15:0] next_value;
    next_start = 1'b0;
    next_value = 16'($urandom);
    if (rst) begin
      next_start = 1'b0;
    end else if (start && !taken) begin
      next_start = 1'b1;
      next_value = value;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (value_queue.size() > 0) begin
      next_value = value_queue.pop_front();
      gap_left = gap_queue.pop_front();
      next_start = 1'b1;
    end
    start <= next_start;
    value <= next_value;
  end

  // request capture and result checking
  always @(posedge clk) begin
    display_t want;
    segs_t got;
    cycles++;
    got.units = units_segments;
    got.tens = tens_segments;
    got.hundreds = hundreds_segments;
    got.thousands = thousands_segments;
    got.err = out_of_range;
    if (!rst && done) begin
      if (pending_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: units %0d tens %0d hundreds %0d thousands %0d err %0b",
                   got.units, got.tens, got.hundreds, got.thousands, got.err);
      end else begin
        want = pending_displays.pop_front();
        if (got.units !== want.segs.units || got.tens !== want.segs.tens ||
            got.hundreds !== want.segs.hundreds ||
            got.thousands !== want.segs.thousands || got.err !== want.segs.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch for %0d: exp %0d/%0d/%0d/%0d err %0b, got %0d/%0d/%0d/%0d err %0b",
                     want.value, want.segs.thousands, want.segs.hundreds, want.segs.tens,
                     want.segs.units, want.segs.err, got.thousands, got.hundreds,
                     got.tens, got.units, got.err);
        end
      end
    end
    taken = !rst && start && !busy;
    if (taken) begin
      want.value = value;
      want.segs = predict_display(value);
      pending_displays.push_back(want);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("decimal_to_seven_segment regression: fail");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] directed [$];
    bit burst;
    rst = 1'b1;
    burst = 1'b0;
    directed = '{16'sd0, 16'sd1, 16'sd9, 16'sd10, 16'sd99, 16'sd100, 16'sd101,
                 16'sd999, 16'sd1000, 16'sd1001, 16'sd1010, 16'sd2345, 16'sd6789,
                 16'sd9990, 16'sd9999, 16'sd10000, 16'sd32767, -16'sd1, -16'sd9999,
                 -16'sd32768, 16'sd5000, 16'sd8008, 16'sd4321};
    foreach (directed[i]) begin
      value_queue.push_back(directed[i]);
      gap_queue.push_back($urandom_range(0, 2));
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0)
        burst = !burst;
      value_queue.push_back(draw_value());
      gap_queue.push_back(burst ? 0 : $urandom_range(0, 9));
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (value_queue.size() > 0 || start || pending_displays.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_displays.size() == 0) begin
      $display("decimal_to_seven_segment regression: pass");
    end else begin
      $display("decimal_to_seven_segment regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/d7s_pkg.sv
sv/d7s_digit_split.sv
sv/d7s_seg_encode.sv
sv/decimal_to_seven_segment.sv
sv/d7s_checker.sv
tb/sv/tb_decimal_to_seven_segment.sv
